/* rtl/core/u8seg_pkg.sv */
// ============================================================================
// u8seg_pkg
// Shared types, constants and byte classifiers for the UTF-8 segmenter.
// ============================================================================
package u8seg_pkg;

    // Ring buffer address width (128 bytes: room for one filling segment
    // plus the segments still draining behind it).
    localparam int PTR_W = 7;
    localparam int FILL_W = 7;
    localparam int POS_W = 6;
    localparam int CNT_W = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_HARD_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_MIN = 1'b1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic [CFG_DATA_W-1:0] HARD_MIN_RESET = 6'd10;
    localparam logic [CFG_DATA_W-1:0] SOFT_MIN_RESET = 6'd28;

    localparam logic [7:0] PAD_MAX = 8'h20;
    localparam logic [7:0] CHR_DEL = 8'h7F;
    localparam logic [7:0] CHR_DOT = 8'h2E;
    localparam logic [7:0] CHR_BANG = 8'h21;
    localparam logic [7:0] CHR_QUEST = 8'h3F;
    localparam logic [7:0] CHR_SEMI = 8'h3B;
    localparam logic [7:0] CHR_NL = 8'h0A;
    localparam logic [7:0] CHR_COMMA = 8'h2C;

    // CJK punctuation, three-byte sequences
    localparam logic [7:0] CJK_STOP_B0 = 8'hE3;
    localparam logic [7:0] CJK_STOP_B1 = 8'h80;
    localparam logic [7:0] CJK_STOP_B2 = 8'h82;
    localparam logic [7:0] CJK_FW_B0 = 8'hEF;
    localparam logic [7:0] CJK_FW_B1 = 8'hBC;
    localparam logic [7:0] CJK_FW_BANG = 8'h81;
    localparam logic [7:0] CJK_FW_QUEST = 8'h9F;
    localparam logic [7:0] CJK_FW_SEMI = 8'h9B;
    localparam logic [7:0] CJK_FW_COMMA = 8'h8C;
    localparam logic [7:0] CJK_FW_COLON = 8'h9A;

    typedef enum logic [1:0] {
        STOP_NONE = 2'd0,
        STOP_HARD = 2'd1,
        STOP_SOFT = 2'd2
    } stop_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       segment_last;
        logic       forced_cut;
    } out_item_t;

    // One segment handed from front to back: trimmed span plus raw end.
    typedef struct packed {
        logic [PTR_W-1:0]  start;
        logic [FILL_W-1:0] len;
        logic [PTR_W-1:0]  end_ptr;
        logic              forced;
    } desc_t;

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        logic [7:0]       data;
    } wr_port_t;

    function automatic logic is_padding(input logic [7:0] b);
        return (b <= PAD_MAX) || (b == CHR_DEL);
    endfunction

    function automatic logic [2:0] lead_width(input logic [7:0] b);
        logic [2:0] w;
        if (b[7] == 1'b0) w = 3'd1;
        else if (b[7:5] == 3'b110) w = 3'd2;
        else if (b[7:4] == 4'b1110) w = 3'd3;
        else if (b[7:3] == 5'b11110) w = 3'd4;
        else w = 3'd1;
        return w;
    endfunction

    function automatic stop_t class1(input logic [7:0] b);
        stop_t c;
        unique case (b) inside
            CHR_DOT, CHR_BANG, CHR_QUEST, CHR_SEMI, CHR_NL: c = STOP_HARD;
            CHR_COMMA: c = STOP_SOFT;
            default: c = STOP_NONE;
        endcase
        return c;
    endfunction

    function automatic stop_t class3(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2);
        stop_t c;
        c = STOP_NONE;
        if (b0 == CJK_STOP_B0 && b1 == CJK_STOP_B1 && b2 == CJK_STOP_B2) begin
            c = STOP_HARD;
        end
        else if (b0 == CJK_FW_B0 && b1 == CJK_FW_B1) begin
            unique case (b2) inside
                CJK_FW_BANG, CJK_FW_QUEST, CJK_FW_SEMI: c = STOP_HARD;
                CJK_FW_COMMA, CJK_FW_COLON: c = STOP_SOFT;
                default: c = STOP_NONE;
            endcase
        end
        return c;
    endfunction

endpackage

/* rtl/core/u8seg_fifo.sv */
// ============================================================================
// u8seg_fifo
// Two-entry queue of segment descriptors between front and back.
// ============================================================================
module u8seg_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  u8seg_pkg::desc_t  push_desc,
    output logic              full,
    input  logic              pop,
    output u8seg_pkg::desc_t  pop_desc,
    output logic              not_empty
);

    u8seg_pkg::desc_t entry_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_desc = entry_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) entry_reg[wp_reg] <= push_desc;
    end

endmodule

/* rtl/core/u8seg_front.sv */
// ============================================================================
// u8seg_front
// Accepts bytes, tracks code points and trim bounds, decides cuts and
// queues one descriptor per segment.
// ============================================================================
module u8seg_front #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  u8seg_pkg::in_item_t                    in_data,
    input  logic [u8seg_pkg::CFG_DATA_W-1:0]       hard_min,
    input  logic [u8seg_pkg::CFG_DATA_W-1:0]       soft_min,
    input  logic [u8seg_pkg::PTR_W-1:0]            rel_ptr,
    input  logic                                   q_full,
    output logic                                   q_push,
    output u8seg_pkg::desc_t                       q_desc,
    output u8seg_pkg::wr_port_t                    wr
);

    localparam logic [u8seg_pkg::FILL_W-1:0] FILL_MAX = u8seg_pkg::FILL_W'(BUFFER_BYTES);
    localparam logic [u8seg_pkg::CNT_W-1:0] PC_MAX = '1;

    logic [u8seg_pkg::PTR_W-1:0]  base_reg, base_next;
    logic [u8seg_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [u8seg_pkg::CNT_W-1:0]  pc_reg, pc_next;
    logic [1:0]                   bl_reg, bl_next;
    logic [u8seg_pkg::POS_W-1:0]  ps_reg, ps_next;
    logic                         pt3_reg, pt3_next;
    logic                         has_reg, has_next;
    logic [u8seg_pkg::POS_W-1:0]  first_reg, first_next;
    logic [u8seg_pkg::POS_W-1:0]  last_reg, last_next;
    logic                         sn_has_reg, sn_has_next;
    logic [u8seg_pkg::POS_W-1:0]  sn_last_reg, sn_last_next;
    logic [7:0]                   h0_reg, h0_next;
    logic [7:0]                   h1_reg, h1_next;

    logic                         accept;
    logic [u8seg_pkg::PTR_W-1:0]  wr_ptr;
    logic [u8seg_pkg::PTR_W-1:0]  occ;
    logic [7:0]                   b;
    logic [u8seg_pkg::POS_W-1:0]  pos;
    logic [2:0]                   lw;
    logic [u8seg_pkg::FILL_W-1:0] fill_inc;
    logic [u8seg_pkg::CNT_W-1:0]  pc_inc;
    logic                         complete;
    u8seg_pkg::stop_t             cls;
    logic                         stop_cut;
    logic [1:0]                   lo_k;
    logic [1:0]                   lo_idx;
    logic [7:0]                   lo_b;
    logic                         lo_has;
    logic [u8seg_pkg::POS_W-1:0]  lo_first;
    logic [u8seg_pkg::POS_W-1:0]  lo_last;

    function automatic u8seg_pkg::desc_t make_desc(
        input logic [u8seg_pkg::PTR_W-1:0]  base,
        input logic                         has,
        input logic [u8seg_pkg::POS_W-1:0]  first,
        input logic [u8seg_pkg::POS_W-1:0]  last,
        input logic [u8seg_pkg::FILL_W-1:0] cut,
        input logic                         forced
    );
        u8seg_pkg::desc_t d;
        d.start = base + {1'b0, first};
        d.len = has ? ({1'b0, last} - {1'b0, first} + 7'd1) : '0;
        d.end_ptr = base + cut;
        d.forced = forced;
        return d;
    endfunction

    assign wr_ptr = base_reg + fill_reg;
    assign occ = wr_ptr - rel_ptr;
    // Hold input while the queue is full or the ring holds 127 unreleased bytes.
    assign in_stall = q_full || (occ == '1);
    assign accept = in_valid && !in_stall;
    assign b = in_data.data_byte;
    assign pos = fill_reg[u8seg_pkg::POS_W-1:0];

    always_comb
    begin
        base_next = base_reg;
        fill_next = fill_reg;
        pc_next = pc_reg;
        bl_next = bl_reg;
        ps_next = ps_reg;
        pt3_next = pt3_reg;
        has_next = has_reg;
        first_next = first_reg;
        last_next = last_reg;
        sn_has_next = sn_has_reg;
        sn_last_next = sn_last_reg;
        h0_next = h0_reg;
        h1_next = h1_reg;
        q_push = 1'b0;
        q_desc = '0;
        wr.en = 1'b0;
        wr.addr = wr_ptr;
        wr.data = b;
        lw = u8seg_pkg::lead_width(b);
        fill_inc = fill_reg + 7'd1;
        pc_inc = (pc_reg == PC_MAX) ? pc_reg : pc_reg + 6'd1;
        complete = 1'b0;
        cls = u8seg_pkg::STOP_NONE;
        stop_cut = 1'b0;
        lo_k = '0;
        lo_idx = '0;
        lo_b = '0;
        lo_has = 1'b0;
        lo_first = '0;
        lo_last = '0;

        if (accept)
        begin
            if (in_data.kind == u8seg_pkg::KIND_FLUSH)
            begin
                // Flush: ship whatever is buffered, drop point tracking.
                q_push = 1'b1;
                q_desc = make_desc(base_reg, has_reg, first_reg, last_reg, fill_reg, 1'b0);
                base_next = base_reg + fill_reg;
                fill_next = '0;
                pc_next = '0;
                bl_next = '0;
                ps_next = '0;
                has_next = 1'b0;
            end
            else
            begin
                wr.en = 1'b1;
                h0_next = b;
                h1_next = h0_reg;

                if (bl_reg == 2'd0)
                begin
                    ps_next = pos;
                    bl_next = 2'(lw - 3'd1);
                    pt3_next = (lw == 3'd3);
                    sn_has_next = has_reg;
                    sn_last_next = last_reg;
                end
                else
                begin
                    bl_next = bl_reg - 2'd1;
                end

                if (!u8seg_pkg::is_padding(b))
                begin
                    if (!has_reg) first_next = pos;
                    last_next = pos;
                    has_next = 1'b1;
                end

                complete = (bl_next == 2'd0);
                if (complete)
                begin
                    if (bl_reg == 2'd0) cls = u8seg_pkg::class1(b);
                    else if (pt3_reg) cls = u8seg_pkg::class3(h1_reg, h0_reg, b);
                end
                stop_cut = complete &&
                    (((cls == u8seg_pkg::STOP_HARD) && (pc_inc >= hard_min)) ||
                     ((cls == u8seg_pkg::STOP_SOFT) && (pc_inc >= soft_min)));

                // Bytes of a split point that carry over into the next segment.
                lo_k = 2'(FILL_MAX - {1'b0, ps_next});
                for (int j = 0; j < 3; j++)
                begin
                    if (2'(j) < lo_k)
                    begin
                        lo_idx = lo_k - 2'd1 - 2'(j);
                        lo_b = (lo_idx == 2'd0) ? b : ((lo_idx == 2'd1) ? h0_reg : h1_reg);
                        if (!u8seg_pkg::is_padding(lo_b))
                        begin
                            if (!lo_has) lo_first = u8seg_pkg::POS_W'(j);
                            lo_last = u8seg_pkg::POS_W'(j);
                            lo_has = 1'b1;
                        end
                    end
                end

                if (stop_cut)
                begin
                    q_push = 1'b1;
                    q_desc = make_desc(base_reg, has_next, first_next, last_next,
                                       fill_inc, 1'b0);
                    base_next = base_reg + fill_inc;
                    fill_next = '0;
                    pc_next = '0;
                    ps_next = '0;
                    has_next = 1'b0;
                end
                else if (fill_inc == FILL_MAX)
                begin
                    q_push = 1'b1;
                    pc_next = '0;
                    if (bl_next != 2'd0 && ps_next != '0)
                    begin
                        // Cut before the unfinished point; keep its bytes.
                        q_desc = make_desc(base_reg, sn_has_next, first_next, sn_last_next,
                                           {1'b0, ps_next}, 1'b1);
                        base_next = base_reg + {1'b0, ps_next};
                        fill_next = FILL_MAX - {1'b0, ps_next};
                        has_next = lo_has;
                        first_next = lo_first;
                        last_next = lo_last;
                        sn_has_next = 1'b0;
                        sn_last_next = '0;
                        ps_next = '0;
                    end
                    else
                    begin
                        q_desc = make_desc(base_reg, has_next, first_next, last_next,
                                           fill_inc, 1'b1);
                        base_next = base_reg + fill_inc;
                        fill_next = '0;
                        bl_next = '0;
                        ps_next = '0;
                        has_next = 1'b0;
                    end
                end
                else
                begin
                    fill_next = fill_inc;
                    if (complete) pc_next = pc_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            fill_reg <= '0;
            pc_reg <= '0;
            bl_reg <= '0;
            ps_reg <= '0;
            pt3_reg <= 1'b0;
            has_reg <= 1'b0;
            sn_has_reg <= 1'b0;
        end
        else
        begin
            base_reg <= base_next;
            fill_reg <= fill_next;
            pc_reg <= pc_next;
            bl_reg <= bl_next;
            ps_reg <= ps_next;
            pt3_reg <= pt3_next;
            has_reg <= has_next;
            sn_has_reg <= sn_has_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        last_reg <= last_next;
        sn_last_reg <= sn_last_next;
        h0_reg <= h0_next;
        h1_reg <= h1_next;
    end

endmodule

/* rtl/core/u8seg_back.sv */
// ============================================================================
// u8seg_back
// Owns the byte ring; drains queued segments into a two-entry output buffer
// at one byte per cycle while that buffer has room.
// ============================================================================
module u8seg_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  u8seg_pkg::wr_port_t           wr,
    input  logic                          desc_valid,
    input  u8seg_pkg::desc_t              desc,
    output logic                          desc_pop,
    output logic [u8seg_pkg::PTR_W-1:0]   rel_ptr,
    output logic                          out_valid,
    input  logic                          out_stall,
    output u8seg_pkg::out_item_t          out_data
);

    localparam int MEM_DEPTH = 1 << u8seg_pkg::PTR_W;

    logic [7:0] mem [MEM_DEPTH];

    logic                          active_reg;
    logic [u8seg_pkg::PTR_W-1:0]   rd_ptr_reg;
    logic [u8seg_pkg::FILL_W-1:0]  remain_reg;
    logic                          forced_reg;
    logic [u8seg_pkg::PTR_W-1:0]   end_reg;
    logic [u8seg_pkg::PTR_W-1:0]   rel_reg;

    u8seg_pkg::out_item_t          ob_reg [2];
    logic                          ob_wp_reg;
    logic                          ob_rp_reg;
    logic [1:0]                    ob_cnt_reg;

    logic out_pop;
    logic room;
    logic issue;

    assign out_valid = (ob_cnt_reg != 2'd0);
    assign out_data = ob_reg[ob_rp_reg];
    assign out_pop = out_valid && !out_stall;
    assign room = (ob_cnt_reg != 2'd2) || out_pop;
    assign issue = active_reg && (remain_reg != '0) && room;
    assign desc_pop = !active_reg && desc_valid;
    assign rel_ptr = rel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            remain_reg <= '0;
            rel_reg <= '0;
            ob_wp_reg <= 1'b0;
            ob_rp_reg <= 1'b0;
            ob_cnt_reg <= 2'd0;
        end
        else
        begin
            if (desc_pop)
            begin
                active_reg <= (desc.len != '0);
                remain_reg <= desc.len;
                // Blank segment: release its bytes at once.
                if (desc.len == '0) rel_reg <= desc.end_ptr;
            end
            else if (issue)
            begin
                remain_reg <= remain_reg - 7'd1;
                if (remain_reg == 7'd1)
                begin
                    active_reg <= 1'b0;
                    rel_reg <= end_reg;
                end
            end

            if (issue) ob_wp_reg <= ~ob_wp_reg;
            if (out_pop) ob_rp_reg <= ~ob_rp_reg;
            if (issue && !out_pop) ob_cnt_reg <= ob_cnt_reg + 2'd1;
            else if (out_pop && !issue) ob_cnt_reg <= ob_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en) mem[wr.addr] <= wr.data;
        if (desc_pop)
        begin
            rd_ptr_reg <= desc.start;
            forced_reg <= desc.forced;
            end_reg <= desc.end_ptr;
        end
        else if (issue)
        begin
            rd_ptr_reg <= rd_ptr_reg + 7'd1;
        end
        if (issue)
        begin
            ob_reg[ob_wp_reg].out_byte <= mem[rd_ptr_reg];
            ob_reg[ob_wp_reg].segment_last <= (remain_reg == 7'd1);
            ob_reg[ob_wp_reg].forced_cut <= forced_reg;
        end
    end

endmodule

/* rtl/core/utf8_sentence_segmenter.sv */
// ============================================================================
// utf8_sentence_segmenter
// Cuts a UTF-8 byte stream into trimmed, speakable segments.
// ============================================================================
//
//   channel  | direction | handshake          | beat payload
//   ---------+-----------+--------------------+------------------------------
//   in       | sink      | in_valid/in_stall  | kind, data_byte
//   out      | source    | out_valid/out_stall| out_byte, segment_last,
//            |           |                    | forced_cut
//   cfg      | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// The front accepts an input beat whenever in_stall is low. The back drains
// a segment from the ring's single read port at one byte per cycle while its
// output buffer has room, and takes the next descriptor only once the
// current segment is done.
// in_stall rises while the two-entry segment queue is full or the 128-byte
// ring holds 127 unreleased bytes.
// Reset clears all control state; the ring needs no clearing pass.
// cfg_ready is always high; writes take effect on the next cycle.
// ============================================================================
module utf8_sentence_segmenter #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  u8seg_pkg::in_item_t                  in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output u8seg_pkg::out_item_t                 out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [u8seg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [u8seg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [u8seg_pkg::CFG_DATA_W-1:0] hard_min_reg;
    logic [u8seg_pkg::CFG_DATA_W-1:0] soft_min_reg;

    logic                        q_push;
    logic                        q_full;
    logic                        q_pop;
    logic                        q_not_empty;
    u8seg_pkg::desc_t            q_push_desc;
    u8seg_pkg::desc_t            q_pop_desc;
    u8seg_pkg::wr_port_t         wr;
    logic [u8seg_pkg::PTR_W-1:0] rel_ptr;

    // Config port never back-pressures.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hard_min_reg <= u8seg_pkg::HARD_MIN_RESET;
            soft_min_reg <= u8seg_pkg::SOFT_MIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                u8seg_pkg::REG_HARD_MIN: hard_min_reg <= cfg_data;
                u8seg_pkg::REG_SOFT_MIN: soft_min_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front: track points and trim bounds, write bytes into the ring,
    // push a descriptor on every cut or flush.
    u8seg_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .hard_min (hard_min_reg),
        .soft_min (soft_min_reg),
        .rel_ptr  (rel_ptr),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_desc   (q_push_desc),
        .wr       (wr)
    );

    // Decouple: front keeps filling while the back drains earlier segments.
    u8seg_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .pop_desc  (q_pop_desc),
        .not_empty (q_not_empty)
    );

    // Back: read trimmed span byte by byte, release ring space when done.
    u8seg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .desc_valid (q_not_empty),
        .desc       (q_pop_desc),
        .desc_pop   (q_pop),
        .rel_ptr    (rel_ptr),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

/* rtl/core/u8seg_sva.sv */
// ============================================================================
// u8seg_sva
// Port-level checks on the segmenter's output stream.
// ============================================================================
module u8seg_sva (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  u8seg_pkg::out_item_t  out_data
);

    logic mid_seg_reg;
    logic seg_forced_reg;
    logic seen_in_reg;
    logic out_acc;
    logic edge_pad;

    assign out_acc = out_valid && !out_stall;
    assign edge_pad = u8seg_pkg::is_padding(out_data.out_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_seg_reg <= 1'b0;
            seg_forced_reg <= 1'b0;
            seen_in_reg <= 1'b0;
        end
        else
        begin
            if (out_acc)
            begin
                mid_seg_reg <= !out_data.segment_last;
                seg_forced_reg <= out_data.forced_cut;
            end
            if (in_valid && !in_stall) seen_in_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    a_forced_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && mid_seg_reg |-> out_data.forced_cut == seg_forced_reg)
        else $error("forced_cut changed inside a segment");

    a_trimmed_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.segment_last || !mid_seg_reg) |-> !edge_pad)
        else $error("segment starts or ends with padding");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_in_reg |-> !out_valid)
        else $error("output before any input beat");

endmodule

bind utf8_sentence_segmenter u8seg_sva u_sva (.*);

/* sim/utf8_sentence_segmenter_checker.sv */
// ----------------------------------------------------------------------------
// utf8_sentence_segmenter_checker
// Watches the input, output and register channels of the segmenter, keeps
// its own copy of the segment buffer and thresholds, and compares every
// output beat against the predicted byte stream.
// ----------------------------------------------------------------------------
module utf8_sentence_segmenter_checker
    import u8seg_pkg::*;
#(
    parameter int SEG_BYTES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_item_t             out_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending_beats,
    output int                    fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]            seg_mem [SEG_BYTES];
    int unsigned           fill;
    int unsigned           points;
    int unsigned           cont_left;
    int unsigned           lead_pos;
    logic [CFG_DATA_W-1:0] hard_min;
    logic [CFG_DATA_W-1:0] soft_min;
    out_item_t             expected_beats [$];
    int                    mismatches = 0;

    assign fail_count = mismatches;

    function automatic int unsigned point_bytes(input logic [7:0] b);
        casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 1;
        endcase
    endfunction

    function automatic logic blank_byte(input logic [7:0] b);
        return (b <= PAD_MAX) || (b == CHR_DEL);
    endfunction

    function automatic stop_t stop_kind(input int unsigned p, input int unsigned w);
        stop_t      k;
        logic [23:0] seq;
        k = STOP_NONE;
        if (w == 1)
        begin
            case (seg_mem[p])
                CHR_DOT, CHR_BANG, CHR_QUEST, CHR_SEMI, CHR_NL: k = STOP_HARD;
                CHR_COMMA: k = STOP_SOFT;
                default: k = STOP_NONE;
            endcase
        end
        else if (w == 3)
        begin
            seq = {seg_mem[p], seg_mem[p + 1], seg_mem[p + 2]};
            case (seq)
                {CJK_STOP_B0, CJK_STOP_B1, CJK_STOP_B2},
                {CJK_FW_B0, CJK_FW_B1, CJK_FW_BANG},
                {CJK_FW_B0, CJK_FW_B1, CJK_FW_QUEST},
                {CJK_FW_B0, CJK_FW_B1, CJK_FW_SEMI}: k = STOP_HARD;
                {CJK_FW_B0, CJK_FW_B1, CJK_FW_COMMA},
                {CJK_FW_B0, CJK_FW_B1, CJK_FW_COLON}: k = STOP_SOFT;
                default: k = STOP_NONE;
            endcase
        end
        return k;
    endfunction

    // Trim the first len bytes and queue what is left, one beat per byte.
    task automatic queue_segment(input int unsigned len, input logic forced);
        int unsigned head;
        int unsigned stop_at;
        out_item_t   beat;
        head = 0;
        stop_at = len;
        while (head < stop_at && blank_byte(seg_mem[head]))
            head++;
        while (stop_at > head && blank_byte(seg_mem[stop_at - 1]))
            stop_at--;
        for (int unsigned i = head; i < stop_at; i++)
        begin
            beat.out_byte = seg_mem[i];
            beat.segment_last = (i + 1 == stop_at);
            beat.forced_cut = forced;
            expected_beats.insert(expected_beats.size(), beat);
        end
    endtask

    task automatic predict_item(input in_item_t item);
        int unsigned pos;
        int unsigned cut;
        stop_t       k;
        if (item.kind == KIND_FLUSH)
        begin
            queue_segment(fill, 1'b0);
            fill = 0;
            points = 0;
            cont_left = 0;
            lead_pos = 0;
            return;
        end
        pos = fill;
        seg_mem[pos] = item.data_byte;
        fill++;
        if (cont_left == 0)
        begin
            lead_pos = pos;
            cont_left = point_bytes(item.data_byte) - 1;
        end
        else
            cont_left--;

        if (cont_left == 0)
        begin
            if (points < 63)
                points++;
            k = stop_kind(lead_pos, pos + 1 - lead_pos);
            if ((k == STOP_HARD && points >= hard_min) ||
                (k == STOP_SOFT && points >= soft_min))
            begin
                queue_segment(fill, 1'b0);
                fill = 0;
                points = 0;
                lead_pos = 0;
                return;
            end
        end

        // Full buffer: cut before an unfinished point and keep its bytes in front, else cut it all.
        if (fill >= SEG_BYTES)
        begin
            cut = fill;
            if (cont_left != 0 && lead_pos > 0)
                cut = lead_pos;
            else
                cont_left = 0;
            queue_segment(cut, 1'b1);
            for (int unsigned i = 0; i < fill - cut; i++)
                seg_mem[i] = seg_mem[cut + i];
            fill -= cut;
            points = 0;
            lead_pos = 0;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            fill = 0;
            points = 0;
            cont_left = 0;
            lead_pos = 0;
            hard_min = HARD_MIN_RESET;
            soft_min = SOFT_MIN_RESET;
            expected_beats.delete();
            pending_beats <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_HARD_MIN: hard_min = cfg_data;
                    REG_SOFT_MIN: soft_min = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_item(in_data);
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected beat, expected none, got byte %h last %b forced %b",
                             $time, out_data.out_byte, out_data.segment_last,
                             out_data.forced_cut);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    check_field("out_byte", want.out_byte, out_data.out_byte);
                    check_field("segment_last", want.segment_last, out_data.segment_last);
                    check_field("forced_cut", want.forced_cut, out_data.forced_cut);
                end
            end
            pending_beats <= expected_beats.size();
        end
    end

endmodule

/* sim/utf8_sentence_segmenter_test.sv */
// ----------------------------------------------------------------------------
// utf8_sentence_segmenter_test
// Drives text bytes and flushes into the segmenter, steps the two cut
// thresholds through several settings between phases, and lets the checker
// compare every emitted beat. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module utf8_sentence_segmenter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import u8seg_pkg::*;

    localparam int SEG_BYTES = 64;
    // The back end takes a descriptor and drains one byte per cycle when not
    // stalled; a blank segment may still be in flight once the last beat is out,
    // so hold this many cycles before touching the registers or ending the run.
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES = 8;

    // Per-phase thresholds; a negative entry means pick one at random.
    localparam int HARD_TAB [PHASES] = '{1, 63, 5, 63, 0, -1, -1, 40};
    localparam int SOFT_TAB [PHASES] = '{1, 63, 63, 1, 3, -1, -1, 63};
    // A longer phase where cuts are rare, so the buffer fills and forces a cut.
    localparam int PHASE_LEN [PHASES] = '{30, 70, 30, 40, 25, 25, 25, 30};

    localparam logic [7:0] ASCII_HARD [5] = '{CHR_DOT, CHR_BANG, CHR_QUEST, CHR_SEMI, CHR_NL};
    localparam logic [23:0] CJK_MARKS [6] = '{
        {CJK_STOP_B0, CJK_STOP_B1, CJK_STOP_B2},
        {CJK_FW_B0, CJK_FW_B1, CJK_FW_BANG},
        {CJK_FW_B0, CJK_FW_B1, CJK_FW_QUEST},
        {CJK_FW_B0, CJK_FW_B1, CJK_FW_SEMI},
        {CJK_FW_B0, CJK_FW_B1, CJK_FW_COMMA},
        {CJK_FW_B0, CJK_FW_B1, CJK_FW_COLON}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int       pending_beats;
    int       fail_count;
    int       send_idle_pct;
    int       recv_stall_pct;
    in_item_t text_q [$];

    utf8_sentence_segmenter #(
        .BUFFER_BYTES(SEG_BYTES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    utf8_sentence_segmenter_checker #(
        .SEG_BYTES(SEG_BYTES)
    ) seg_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending_beats (pending_beats),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: stall at the rate the current phase asks for.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Hard stop on a hung run; far beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("utf8_sentence_segmenter_test failed");
        $finish;
    end

    function automatic in_item_t data_item(input logic [7:0] b);
        return in_item_t'{kind: KIND_DATA, data_byte: b};
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // Append one item at the tail of the pending text.
    task automatic queue_text(input in_item_t item);
        text_q.insert(text_q.size(), item);
    endtask

    // Send one beat. A gap, if any, lowers valid at the step of the previous
    // acceptance, so valid never gets two updates in one step.
    task automatic push_item(input in_item_t item);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(data_item(b));
    endtask

    // Drop valid, wait for every predicted beat, then let the back end drain.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_beats != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_limits(input logic [CFG_DATA_W-1:0] hard_pts,
                              input logic [CFG_DATA_W-1:0] soft_pts);
        write_reg(REG_HARD_MIN, hard_pts);
        write_reg(REG_SOFT_MIN, soft_pts);
        cfg_valid <= 1'b0;
    endtask

    // Append one piece of text: mostly words, spaces and punctuation, with
    // multi-byte points, stray bytes and flushes mixed in.
    task automatic add_text_piece();
        int unsigned pick;
        logic [23:0] mark;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            repeat ($urandom_range(1, 5))
                queue_text(data_item($urandom_range(0, 1) ?
                                     8'($urandom_range(8'h61, 8'h7A)) :
                                     8'($urandom_range(8'h41, 8'h5A))));
        end
        else if (pick < 50)
            queue_text(data_item(PAD_MAX));
        else if (pick < 56)
        begin
            queue_text(data_item(8'($urandom_range(8'hC2, 8'hDF))));
            queue_text(data_item(cont_byte()));
        end
        else if (pick < 62)
        begin
            queue_text(data_item(8'($urandom_range(8'hE0, 8'hEF))));
            repeat (2) queue_text(data_item(cont_byte()));
        end
        else if (pick < 66)
        begin
            queue_text(data_item(8'($urandom_range(8'hF0, 8'hF7))));
            repeat (3) queue_text(data_item(cont_byte()));
        end
        else if (pick < 74)
            queue_text(data_item(ASCII_HARD[$urandom_range(0, 4)]));
        else if (pick < 79)
            queue_text(data_item(CHR_COMMA));
        else if (pick < 85)
        begin
            mark = CJK_MARKS[$urandom_range(0, 5)];
            queue_text(data_item(mark[23:16]));
            queue_text(data_item(mark[15:8]));
            queue_text(data_item(mark[7:0]));
        end
        else if (pick < 90)
            queue_text(data_item($urandom_range(0, 3) == 0 ?
                                 CHR_DEL : 8'($urandom_range(0, 32))));
        else if (pick < 96)
            queue_text(data_item(8'($urandom_range(0, 255))));
        else
            queue_text(in_item_t'{kind: KIND_FLUSH,
                                  data_byte: 8'($urandom_range(0, 255))});
    endtask

    initial
    begin
        int sent;
        int hard_lim;
        int soft_lim;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, at reset thresholds: flush on an empty buffer gives
        // nothing, and a segment of padding bytes only is dropped.
        push_item(in_item_t'{kind: KIND_FLUSH, data_byte: 8'hFF});
        push_byte(8'h00);
        push_byte(PAD_MAX);
        push_byte(CHR_DEL);
        push_item(in_item_t'{kind: KIND_FLUSH, data_byte: 8'h00});
        settle();

        // Directed, lowest thresholds: every stop cuts right away.
        set_limits(6'd1, 6'd1);
        push_byte(PAD_MAX);            // leading blank, trimmed
        push_byte(8'h41);              // 'A'
        push_byte(CHR_DOT);            // hard stop
        push_byte(8'h78);              // 'x'
        push_byte(CHR_COMMA);          // soft stop
        push_byte(CJK_STOP_B0);        // CJK full stop, alone
        push_byte(CJK_STOP_B1);
        push_byte(CJK_STOP_B2);
        push_byte(CJK_FW_B0);          // CJK comma, alone
        push_byte(CJK_FW_B1);
        push_byte(CJK_FW_COMMA);
        push_byte(CHR_NL);             // newline cut, blank after trim
        push_byte(8'hFF);              // invalid lead, one-byte point
        push_byte(8'h80);              // stray continuation
        push_byte(8'hF0);              // unfinished four-byte point
        push_item(in_item_t'{kind: KIND_FLUSH, data_byte: 8'h5A});
        settle();

        // Random phases: thresholds and idling change at every phase boundary.
        // Leftover bytes of a piece carry into the next phase on purpose.
        for (int p = 0; p < PHASES; p++)
        begin
            hard_lim = (HARD_TAB[p] < 0) ? $urandom_range(1, 63) : HARD_TAB[p];
            soft_lim = (SOFT_TAB[p] < 0) ? $urandom_range(1, 63) : SOFT_TAB[p];
            set_limits(6'(hard_lim), 6'(soft_lim));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            sent = 0;
            while (sent < PHASE_LEN[p])
            begin
                if (text_q.size() == 0)
                    add_text_piece();
                push_item(text_q.pop_front());
                sent++;
            end
            settle();
        end

        // Push out whatever text is still buffered.
        push_item(in_item_t'{kind: KIND_FLUSH, data_byte: 8'($urandom_range(0, 255))});
        settle();

        if (fail_count == 0)
            $display("utf8_sentence_segmenter_test passed");
        else
            $display("utf8_sentence_segmenter_test failed");
        $finish;
    end

endmodule
